### hw/rtl/hrp_pkg.sv
// Shared constants, types and lookup tables of the HTTP response header parser.
package hrp_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFF_W = 13;
    localparam int EXT_W = (POS_W > OFF_W) ? POS_W : OFF_W;

    localparam logic [4:0] NAME_LEN = 5'd14;
    localparam logic [4:0] VALUE_OFFSET = 5'd16;
    localparam logic [4:0] MATCH_IDLE = 5'd31;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_1 = 8'h31;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [23:0] HEADER_END_PREFIX = 24'h0D0A0D;

    localparam logic [7:0] SIG_TEXT [8] = '{
        8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30
    };

    localparam logic [7:0] NAME_TEXT [16] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        KIND_NOT_HTTP = 2'd0,
        KIND_NO_END   = 2'd1,
        KIND_DONE     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind            result_kind;
        logic [31:0]      status_word;
        logic [31:0]      content_length;
        logic [OFF_W-1:0] body_offset;
        logic [OFF_W-1:0] body_length;
    } t_result;

endpackage

### hw/rtl/hrp_core.sv
// Per-byte parse state and its combinational update, with the result of a packet.
module hrp_core
    import hrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output t_result    o_result,
    output logic       o_result_valid
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    logic [POS_W-1:0] r_pos;
    t_phase           r_phase;
    logic [4:0]       r_idx;
    logic [23:0]      r_prev;
    logic [31:0]      r_status;
    logic [31:0]      r_acc;
    logic             r_digits;
    logic [POS_W-1:0] r_body_start;
    logic             r_sig_ok;
    logic             r_seen;

    logic [POS_W-1:0] n_pos;
    t_phase           n_phase;
    logic [4:0]       n_idx;
    logic [23:0]      n_prev;
    logic [31:0]      n_status;
    logic [31:0]      n_acc;
    logic             n_digits;
    logic [POS_W-1:0] n_body_start;
    logic             n_sig_ok;
    logic             n_seen;

    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] pos_clamped;
    logic             is_digit;
    logic [35:0]      acc_mul;
    logic [31:0]      acc_sat;
    logic             crlf;
    logic             sig_match;
    logic             name_pass;
    logic [POS_W-1:0] body_len_full;
    logic [EXT_W-1:0] body_len_ext;
    logic [EXT_W-1:0] body_off_ext;

    always_comb begin
        pos_inc = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
        if (pos_inc > (POS_W + 1)'(MAX_PACKET_BYTES)) begin
            pos_clamped = POS_W'(MAX_PACKET_BYTES);
        end else begin
            pos_clamped = pos_inc[POS_W-1:0];
        end

        is_digit = (i_data >= CHAR_0) && (i_data <= CHAR_9);
        acc_mul = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                + {28'd0, i_data - CHAR_0};
        acc_sat = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_mul[31:0];
        crlf = (i_data == CHAR_LF) && (r_prev[7:0] == CHAR_CR);

        n_pos        = pos_clamped;
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_prev       = r_prev;
        n_status     = r_status;
        n_acc        = r_acc;
        n_digits     = r_digits;
        n_body_start = r_body_start;
        n_sig_ok     = r_sig_ok;
        n_seen       = r_seen;
        name_pass    = 1'b1;

        if (r_pos < POS_W'(8)) begin
            if (r_pos[2:0] == 3'd7) begin
                sig_match = (i_data == CHAR_0) || (i_data == CHAR_1);
            end else begin
                sig_match = (i_data == SIG_TEXT[r_pos[2:0]]);
            end
            if (!sig_match) begin
                n_sig_ok = 1'b0;
            end
        end else begin
            sig_match = 1'b1;
            if (r_pos < POS_W'(12)) begin
                n_status[8*r_pos[1:0] +: 8] = r_status[8*r_pos[1:0] +: 8] | i_data;
            end
        end

        if (r_phase != PH_BODY) begin
            if (crlf && (r_phase == PH_HEADER) && (r_prev == HEADER_END_PREFIX)) begin
                n_phase      = PH_BODY;
                n_body_start = pos_clamped;
                n_digits     = 1'b0;
                n_idx        = MATCH_IDLE;
            end else if (crlf) begin
                n_phase  = PH_HEADER;
                n_idx    = 5'd0;
                n_digits = 1'b0;
            end else if (r_phase == PH_HEADER) begin
                if (r_digits) begin
                    if (is_digit) begin
                        n_acc     = acc_sat;
                        name_pass = 1'b0;
                    end else begin
                        n_digits = 1'b0;
                    end
                end
                if (name_pass) begin
                    if (r_idx < NAME_LEN) begin
                        if (i_data == NAME_TEXT[r_idx[3:0]]) begin
                            n_idx = r_idx + 5'd1;
                            if (n_idx == NAME_LEN) begin
                                n_seen = 1'b1;
                                n_acc  = 32'd0;
                            end
                        end else begin
                            n_idx = MATCH_IDLE;
                        end
                    end else if (r_idx < VALUE_OFFSET) begin
                        n_idx = r_idx + 5'd1;
                        if (n_idx == VALUE_OFFSET) begin
                            n_digits = 1'b1;
                            n_idx    = MATCH_IDLE;
                        end
                    end
                end
            end
            n_prev = {r_prev[15:0], i_data};
        end

        body_len_full = n_pos - n_body_start;
        body_len_ext  = EXT_W'(body_len_full);
        body_off_ext  = EXT_W'(n_body_start);

        o_result_valid = i_accept && i_last;
        if (!n_sig_ok || (n_pos < POS_W'(8))) begin
            o_result.result_kind    = KIND_NOT_HTTP;
            o_result.status_word    = 32'd0;
            o_result.content_length = 32'd0;
            o_result.body_offset    = '0;
            o_result.body_length    = '0;
        end else begin
            o_result.status_word = n_status;
            if (!n_seen) begin
                o_result.content_length = 32'd0;
            end else if (n_acc == 32'd0) begin
                o_result.content_length = 32'hFFFF_FFFF;
            end else begin
                o_result.content_length = n_acc;
            end
            if (n_phase == PH_BODY) begin
                o_result.result_kind = KIND_DONE;
                o_result.body_offset = body_off_ext[OFF_W-1:0];
                o_result.body_length = body_len_ext[OFF_W-1:0];
            end else begin
                o_result.result_kind = KIND_NO_END;
                o_result.body_offset = '0;
                o_result.body_length = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos        <= '0;
            r_phase      <= PH_FIRST;
            r_idx        <= MATCH_IDLE;
            r_prev       <= 24'd0;
            r_status     <= 32'd0;
            r_acc        <= 32'd0;
            r_digits     <= 1'b0;
            r_body_start <= '0;
            r_sig_ok     <= 1'b1;
            r_seen       <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_prev       <= n_prev;
            r_status     <= n_status;
            r_acc        <= n_acc;
            r_digits     <= n_digits;
            r_body_start <= n_body_start;
            r_sig_ok     <= n_sig_ok;
            r_seen       <= n_seen;
        end
    end

`ifndef ASSERT_OFF
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0) && (r_phase == PH_FIRST))
        else $error("parse state not restarted after the last byte");

    a_digits_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits |-> (r_phase == PH_HEADER))
        else $error("value digits active outside the header lines");

    a_body_start_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_body_start != '0) && (r_body_start <= r_pos))
        else $error("body start inconsistent with byte position");
`endif

endmodule

### hw/rtl/hrp_outreg.sv
// Output register that holds one result item and decouples the two stream sides.
module hrp_outreg
    import hrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_result_valid,
    input  logic    i_out_ready,
    output t_result o_result,
    output logic    o_out_valid,
    output logic    o_in_ready
);

    logic    r_valid;
    t_result r_result;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result_valid) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result_valid) begin
            r_result <= i_result;
        end
    end

endmodule

### hw/rtl/http_response_header_parser_top.sv
// The result item is registered and appears in the cycle after the last byte of a packet is accepted.
// Throughput: one byte per cycle while s_axis_tready is high; it drops while a result item waits unread.
// A packet yields one result item; the output register frees input ready while it drains.
// Reset is synchronous and active low; it clears the parse state and the output valid.
// After each last byte the parse state returns to its reset values for the next packet.
module http_response_header_parser_top
    import hrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // status_word[31:0], content_length[63:32],
                                        // body_offset[76:64], body_length[89:77], zeros
    output logic [1:0]  m_axis_tuser    // result_kind[1:0]
);

    logic    in_accept;
    t_result core_result;
    logic    core_valid;
    t_result out_result;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    hrp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_data         (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .o_result       (core_result),
        .o_result_valid (core_valid)
    );

    hrp_outreg u_outreg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result       (core_result),
        .i_result_valid (core_valid),
        .i_out_ready    (m_axis_tready),
        .o_result       (out_result),
        .o_out_valid    (m_axis_tvalid),
        .o_in_ready     (s_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_result.body_length, out_result.body_offset,
                           out_result.content_length, out_result.status_word};
    assign m_axis_tuser = out_result.result_kind;

endmodule
